// File: design/ccp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_pkg
// Shared widths, types and column tables for the camera centre pipeline.
// ----------------------------------------------------------------------------
package ccp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int MW        = 97;
  localparam int MAGW      = 96;
  localparam int RW        = 128;
  localparam int QW        = 32;
  localparam int NTERM     = 6;
  localparam int LANE_ST   = 5;
  localparam int DIV_ST    = 2 + QW;
  localparam int NST       = LANE_ST + DIV_ST + 1;

  typedef logic signed [DW-1:0] entry_t;
  typedef entry_t               minor_t [3][3];
  typedef logic signed [MW-1:0] det_t;

  localparam logic [1:0] COL_A [NTERM] = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd0, 2'd1};
  localparam logic [1:0] COL_B [NTERM] = '{2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0};
  localparam logic [1:0] COL_C [NTERM] = '{2'd2, 2'd0, 2'd1, 2'd0, 2'd1, 2'd2};

endpackage

// File: design/ccp_minor_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_minor_lane
// Five-stage pipelined exact 3x3 determinant of signed fixed-point entries.
// ----------------------------------------------------------------------------
module ccp_minor_lane (
  input  logic                          clk_i,
  input  ccp_pkg::minor_t               m_i,
  input  logic [ccp_pkg::LANE_ST-1:0]   en_i,
  output ccp_pkg::det_t                 det_o
);

  logic signed [63:0] ab_q [ccp_pkg::NTERM];
  logic signed [63:0] ab_d [ccp_pkg::NTERM];
  ccp_pkg::entry_t    c_q  [ccp_pkg::NTERM];
  logic signed [63:0] hi_q [ccp_pkg::NTERM];
  logic signed [64:0] lo_q [ccp_pkg::NTERM];
  logic signed [63:0] hi_d [ccp_pkg::NTERM];
  logic signed [64:0] lo_d [ccp_pkg::NTERM];
  logic signed [95:0] t_q  [ccp_pkg::NTERM];
  logic signed [95:0] t_d  [ccp_pkg::NTERM];
  ccp_pkg::det_t      sa_q, sb_q, sa_d, sb_d, det_q;

  always_comb begin
    for (int j = 0; j < ccp_pkg::NTERM; j++) begin
      ab_d[j] = 64'(m_i[0][ccp_pkg::COL_A[j]]) * 64'(m_i[1][ccp_pkg::COL_B[j]]);
      lo_d[j] = $signed({1'b0, ab_q[j][31:0]}) * 65'(c_q[j]);
      hi_d[j] = 64'($signed(ab_q[j][63:32])) * 64'(c_q[j]);
      t_d[j]  = $signed({hi_q[j][63:0], 32'd0}) + 96'(lo_q[j]);
    end
    sa_d = ccp_pkg::MW'(t_q[0]) + ccp_pkg::MW'(t_q[1]) + ccp_pkg::MW'(t_q[2]);
    sb_d = ccp_pkg::MW'(t_q[3]) + ccp_pkg::MW'(t_q[4]) + ccp_pkg::MW'(t_q[5]);
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < ccp_pkg::NTERM; j++) begin
      if (en_i[0]) begin
        ab_q[j] <= ab_d[j];
        c_q[j]  <= m_i[2][ccp_pkg::COL_C[j]];
      end
      if (en_i[1]) begin
        hi_q[j] <= hi_d[j];
        lo_q[j] <= lo_d[j];
      end
      if (en_i[2]) t_q[j] <= t_d[j];
    end
    if (en_i[3]) begin
      sa_q <= sa_d;
      sb_q <= sb_d;
    end
    if (en_i[4]) det_q <= sa_q - sb_q;
  end

  assign det_o = det_q;

endmodule

// File: design/ccp_div_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_div_lane
// Pipelined restoring divider, one quotient bit per stage, with overflow and zero-divisor flags.
// ----------------------------------------------------------------------------
module ccp_div_lane (
  input  logic                         clk_i,
  input  ccp_pkg::det_t                num_i,
  input  logic                         num_flip_i,
  input  ccp_pkg::det_t                den_i,
  input  logic                         den_flip_i,
  input  logic [ccp_pkg::DIV_ST-1:0]   en_i,
  output logic [ccp_pkg::QW-1:0]       q_o,
  output logic                         neg_o,
  output logic                         ovf_o,
  output logic                         zero_o
);

  localparam int QW = ccp_pkg::QW;
  localparam int RW = ccp_pkg::RW;

  logic [ccp_pkg::MAGW-1:0] nmag_q, dmag_q;
  logic                     s0_q, z0_q;
  ccp_pkg::det_t            nneg, dneg;

  logic [RW-1:0]            r_q [QW+1];
  logic [ccp_pkg::MAGW-1:0] d_q [QW+1];
  logic [QW-1:0]            qq_q [QW+1];
  logic                     s_q [QW+1];
  logic                     o_q [QW+1];
  logic                     z_q [QW+1];
  logic [RW-1:0]            r0_d;

  assign nneg = -num_i;
  assign dneg = -den_i;
  assign r0_d = RW'(nmag_q) << ccp_pkg::FRAC_BITS;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      nmag_q <= num_i[ccp_pkg::MW-1] ? nneg[ccp_pkg::MAGW-1:0] : num_i[ccp_pkg::MAGW-1:0];
      dmag_q <= den_i[ccp_pkg::MW-1] ? dneg[ccp_pkg::MAGW-1:0] : den_i[ccp_pkg::MAGW-1:0];
      s0_q   <= num_i[ccp_pkg::MW-1] ^ num_flip_i ^ den_i[ccp_pkg::MW-1] ^ den_flip_i;
      z0_q   <= (den_i == '0);
    end
    if (en_i[1]) begin
      r_q[0]  <= r0_d;
      d_q[0]  <= dmag_q;
      qq_q[0] <= '0;
      s_q[0]  <= s0_q;
      o_q[0]  <= (r0_d >= {dmag_q, 32'd0});
      z_q[0]  <= z0_q;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_bit
    logic [RW-1:0] dsh;
    logic          take;
    assign dsh  = RW'(d_q[k-1]) << (QW - k);
    assign take = (r_q[k-1] >= dsh);
    always_ff @(posedge clk_i) begin
      if (en_i[k+1]) begin
        r_q[k]  <= take ? r_q[k-1] - dsh : r_q[k-1];
        d_q[k]  <= d_q[k-1];
        qq_q[k] <= {qq_q[k-1][QW-2:0], take};
        s_q[k]  <= s_q[k-1];
        o_q[k]  <= o_q[k-1];
        z_q[k]  <= z_q[k-1];
      end
    end
  end

  assign q_o    = qq_q[QW];
  assign neg_o  = s_q[QW];
  assign ovf_o  = o_q[QW];
  assign zero_o = z_q[QW];

endmodule

// File: design/camera_centre_from_projection.sv
`timescale 1ns / 1ps
// the five-stage minor lanes feed the 32-stage bit-per-stage divider lanes
// throughput: one matrix per cycle while out_stall_i is low; pipeline bubbles collapse under output stall
// reset clears all stage valid bits; payload registers are not reset
// ----------------------------------------------------------------------------
// camera_centre_from_projection
// Four determinant lanes feed three divider lanes that give the camera centre.
// ----------------------------------------------------------------------------
module camera_centre_from_projection (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [31:0]   p_r0c0_i, p_r0c1_i, p_r0c2_i, p_r0c3_i,
  input  logic signed [31:0]   p_r1c0_i, p_r1c1_i, p_r1c2_i, p_r1c3_i,
  input  logic signed [31:0]   p_r2c0_i, p_r2c1_i, p_r2c2_i, p_r2c3_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [31:0]   centre_x_o,
  output logic signed [31:0]   centre_y_o,
  output logic signed [31:0]   centre_z_o,
  output logic                 at_infinity_o
);

  localparam int NST = ccp_pkg::NST;
  localparam int LST = ccp_pkg::LANE_ST;
  localparam int QW  = ccp_pkg::QW;

  ccp_pkg::entry_t p [3][4];
  ccp_pkg::minor_t mx, my, mz, mt;
  ccp_pkg::det_t   dx, dy, dz, dt;
  logic [NST-1:0]  v_q, en;

  logic [QW-1:0] q   [3];
  logic          neg [3], ovf [3], zero [3];
  logic signed [QW-1:0] res_q [3];
  logic          inf_q;

  assign p[0] = '{p_r0c0_i, p_r0c1_i, p_r0c2_i, p_r0c3_i};
  assign p[1] = '{p_r1c0_i, p_r1c1_i, p_r1c2_i, p_r1c3_i};
  assign p[2] = '{p_r2c0_i, p_r2c1_i, p_r2c2_i, p_r2c3_i};

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mx[r] = '{p[r][1], p[r][2], p[r][3]};
      my[r] = '{p[r][0], p[r][2], p[r][3]};
      mz[r] = '{p[r][0], p[r][1], p[r][3]};
      mt[r] = '{p[r][0], p[r][1], p[r][2]};
    end
  end

  always_comb begin
    en[NST-1] = !v_q[NST-1] || !out_stall_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  ccp_minor_lane u_lane_x (.clk_i, .m_i(mx), .en_i(en[LST-1:0]), .det_o(dx));
  ccp_minor_lane u_lane_y (.clk_i, .m_i(my), .en_i(en[LST-1:0]), .det_o(dy));
  ccp_minor_lane u_lane_z (.clk_i, .m_i(mz), .en_i(en[LST-1:0]), .det_o(dz));
  ccp_minor_lane u_lane_t (.clk_i, .m_i(mt), .en_i(en[LST-1:0]), .det_o(dt));

  ccp_div_lane u_div_x (
    .clk_i, .num_i(dx), .num_flip_i(1'b0), .den_i(dt), .den_flip_i(1'b1),
    .en_i(en[NST-2:LST]), .q_o(q[0]), .neg_o(neg[0]), .ovf_o(ovf[0]), .zero_o(zero[0])
  );
  ccp_div_lane u_div_y (
    .clk_i, .num_i(dy), .num_flip_i(1'b1), .den_i(dt), .den_flip_i(1'b1),
    .en_i(en[NST-2:LST]), .q_o(q[1]), .neg_o(neg[1]), .ovf_o(ovf[1]), .zero_o(zero[1])
  );
  ccp_div_lane u_div_z (
    .clk_i, .num_i(dz), .num_flip_i(1'b0), .den_i(dt), .den_flip_i(1'b1),
    .en_i(en[NST-2:LST]), .q_o(q[2]), .neg_o(neg[2]), .ovf_o(ovf[2]), .zero_o(zero[2])
  );

  // merge: saturate, apply sign, zero at infinity
  always_ff @(posedge clk_i) begin
    if (en[NST-1]) begin
      for (int i = 0; i < 3; i++) begin
        logic [QW:0] lim, mag;
        lim = neg[i] ? {2'b01, {(QW-1){1'b0}}} : {2'b00, {(QW-1){1'b1}}};
        mag = (ovf[i] || ({1'b0, q[i]} > lim)) ? lim : {1'b0, q[i]};
        if (zero[i])     res_q[i] <= '0;
        else if (neg[i]) res_q[i] <= QW'(-mag);
        else             res_q[i] <= QW'(mag);
      end
      inf_q <= zero[0];
    end
  end

  assign in_stall_o    = !en[0];
  assign out_valid_o   = v_q[NST-1];
  assign centre_x_o    = res_q[0];
  assign centre_y_o    = res_q[1];
  assign centre_z_o    = res_q[2];
  assign at_infinity_o = inf_q;

endmodule

// File: design/ccp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccp_checker
// Port-level checks for the camera centre pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module ccp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic signed [31:0]  centre_x_o,
  input logic signed [31:0]  centre_y_o,
  input logic signed [31:0]  centre_z_o,
  input logic                at_infinity_o
);

  // a camera at infinity carries zero coordinates
  a_inf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && at_infinity_o) |->
      (centre_x_o == 0 && centre_y_o == 0 && centre_z_o == 0))
    else $error("at_infinity with nonzero coordinates");

  // an empty output never backs up the input
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output empty");

  // stall on input needs a waiting output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output stall");

  // valid and centre_x held while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(centre_x_o)))
    else $error("stalled result dropped or changed");

endmodule

bind camera_centre_from_projection ccp_checker u_ccp_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i,
  .centre_x_o, .centre_y_o, .centre_z_o, .at_infinity_o
);
